// File: sv/sha_pkg.sv
`default_nettype none
package sha_pkg;

  localparam int unsigned CountW = 61;

  typedef struct packed {
    logic       load_byte;
    logic       pad_begin;
    logic       pad_step;
    logic       len_write;
    logic       comp_start;
    logic       comp_round;
    logic       comp_finish;
    logic       hash_init;
    logic       count_clear;
    logic       shift_out;
  } sha_cmd_t;

  typedef struct packed {
    logic       block_full;
    logic       pad_room;
    logic       pad_done;
    logic       round_last;
    logic [5:0] byte_pos;
  } sha_stat_t;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    unique case (idx)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] h;
    unique case (idx)
      3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
      3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
      3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
      3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
    endcase
    return h;
  endfunction

endpackage
`default_nettype wire

// File: sv/sha_datapath.sv
`default_nettype none
module sha_datapath
  import sha_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire sha_cmd_t    cmd_i,
  input  wire logic [7:0]  data_byte_i,
  output sha_stat_t        stat_o,
  output logic [31:0]      digest_word_o
);

  logic [31:0]       w_q [16];
  logic [31:0]       v_q [8];
  logic [31:0]       h_q [8];
  logic [CountW-1:0] count_q;
  logic [5:0]        round_q;
  logic [5:0]        pad_q;

  logic [5:0]  pos;
  logic [31:0] wt, t1, t2, s0w, s1w, wnew, ev, av, ch, maj, se, sa;
  logic [31:0] bmask, bval;
  logic [5:0]  wpos;
  logic [7:0]  wbyte;
  logic        bwrite;
  logic [63:0] bits;

  assign pos  = count_q[5:0];
  assign bits = {count_q, 3'b000};

  always_comb begin
    bwrite = cmd_i.load_byte | cmd_i.pad_begin | cmd_i.pad_step;
    wpos   = (cmd_i.load_byte | cmd_i.pad_begin) ? pos : pad_q;
    wbyte  = cmd_i.load_byte ? data_byte_i : (cmd_i.pad_begin ? 8'h80 : 8'h00);
    bmask  = 32'hff << ((5'd3 - {3'd0, wpos[1:0]}) * 5'd8);
    bval   = {24'd0, wbyte} << ((5'd3 - {3'd0, wpos[1:0]}) * 5'd8);
  end

  always_comb begin
    wt   = w_q[0];
    s0w  = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
    s1w  = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
           ^ (w_q[14] >> 10);
    wnew = w_q[0] + s0w + w_q[9] + s1w;
    ev   = v_q[4];
    av   = v_q[0];
    se   = {ev[5:0], ev[31:6]} ^ {ev[10:0], ev[31:11]} ^ {ev[24:0], ev[31:25]};
    sa   = {av[1:0], av[31:2]} ^ {av[12:0], av[31:13]} ^ {av[21:0], av[31:22]};
    ch   = (ev & v_q[5]) ^ (~ev & v_q[6]);
    maj  = (av & v_q[1]) ^ (av & v_q[2]) ^ (v_q[1] & v_q[2]);
    t1   = v_q[7] + se + ch + round_k(round_q) + wt;
    t2   = sa + maj;
  end

  // The schedule is a 16-word shift line; word 0 is W[t] for the current round.
  always_ff @(posedge clk_i) begin
    if (bwrite) begin
      w_q[wpos[5:2]] <= (w_q[wpos[5:2]] & ~bmask) | bval;
    end else if (cmd_i.len_write) begin
      w_q[14] <= bits[63:32];
      w_q[15] <= bits[31:0];
    end else if (cmd_i.comp_round) begin
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= wnew;
    end
    if (cmd_i.comp_start) begin
      for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
    end else if (cmd_i.comp_round) begin
      v_q[0] <= t1 + t2;
      v_q[1] <= v_q[0];
      v_q[2] <= v_q[1];
      v_q[3] <= v_q[2];
      v_q[4] <= v_q[3] + t1;
      v_q[5] <= v_q[4];
      v_q[6] <= v_q[5];
      v_q[7] <= v_q[6];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
      count_q <= '0;
      round_q <= '0;
      pad_q   <= '0;
    end else begin
      if (cmd_i.hash_init) begin
        for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
      end else if (cmd_i.comp_finish) begin
        for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
      end else if (cmd_i.shift_out) begin
        for (int i = 0; i < 7; i++) h_q[i] <= h_q[i+1];
        h_q[7] <= h_q[0];
      end
      if (cmd_i.count_clear) count_q <= '0;
      else if (cmd_i.load_byte) count_q <= count_q + 1'b1;
      if (cmd_i.comp_start) round_q <= '0;
      else if (cmd_i.comp_round) round_q <= round_q + 1'b1;
      if (cmd_i.pad_begin) pad_q <= pos + 1'b1;
      else if (cmd_i.pad_step) pad_q <= pad_q + 1'b1;
      else if (cmd_i.comp_start) pad_q <= '0;
    end
  end

  always_comb begin
    stat_o.block_full = (pos == 6'd63);
    stat_o.pad_room   = (pos < 6'd56);
    stat_o.pad_done   = (pad_q == 6'd63);
    stat_o.round_last = (round_q == 6'd63);
    stat_o.byte_pos   = pos;
  end

  assign digest_word_o = h_q[0];

endmodule
`default_nettype wire

// File: sv/sha_ctrl.sv
`default_nettype none
module sha_ctrl
  import sha_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic      byte_valid_i,
  input  wire logic      is_last_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output logic [2:0]     word_index_o,
  output logic           last_word_o,
  input  wire sha_stat_t stat_i,
  output sha_cmd_t       cmd_o
);

  typedef enum logic [3:0] {
    StIdle, StPadFirst, StPadFill, StRounds, StFinish, StClearBlk, StLenWrite,
    StFinal, StFinalDone, StOut
  } state_e;

  // Why a compression was launched decides where to go when it ends.
  typedef enum logic [1:0] { CmpData, CmpPadExtra, CmpFinal } cmp_e;

  state_e      state_q;
  cmp_e        why_q;
  logic        last_q;
  logic [2:0]  idx_q;
  logic        acc, out_acc;

  assign in_ready_o   = (state_q == StIdle);
  assign acc          = in_valid_i & in_ready_o;
  assign out_valid_o  = (state_q == StOut);
  assign out_acc      = out_valid_o & out_ready_i;
  assign word_index_o = idx_q;
  assign last_word_o  = (idx_q == 3'd7);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        cmd_o.load_byte = acc & byte_valid_i;
        cmd_o.comp_start = acc & byte_valid_i & stat_i.block_full;
      end
      StPadFirst: begin
        cmd_o.pad_begin  = 1'b1;
        cmd_o.comp_start = (stat_i.byte_pos == 6'd63);
      end
      StPadFill: begin
        cmd_o.pad_step   = 1'b1;
        cmd_o.comp_start = stat_i.pad_done & ~stat_i.pad_room;
      end
      StRounds:   cmd_o.comp_round = 1'b1;
      StFinish:   cmd_o.comp_finish = 1'b1;
      StClearBlk: cmd_o.pad_step = 1'b1;
      StLenWrite: begin
        cmd_o.len_write  = 1'b1;
        cmd_o.comp_start = 1'b1;
      end
      StFinal:     cmd_o.comp_round = 1'b1;
      StFinalDone: begin
        cmd_o.comp_finish = 1'b1;
        cmd_o.count_clear = 1'b1;
      end
      StOut: begin
        cmd_o.shift_out = out_acc & ~last_word_o;
        cmd_o.hash_init = out_acc & last_word_o;
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      why_q   <= CmpData;
      last_q  <= 1'b0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        StIdle: begin
          if (acc) begin
            last_q <= is_last_i;
            if (byte_valid_i && stat_i.block_full) begin
              why_q   <= CmpData;
              state_q <= StRounds;
            end else if (is_last_i) begin
              state_q <= StPadFirst;
            end
          end
        end
        StPadFirst: begin
          // A marker in the last byte of the block leaves nothing to fill.
          if (stat_i.byte_pos == 6'd63) begin
            why_q   <= CmpPadExtra;
            state_q <= StRounds;
          end else begin
            state_q <= StPadFill;
          end
        end
        StPadFill: begin
          if (stat_i.pad_done) begin
            if (stat_i.pad_room) begin
              state_q <= StLenWrite;
            end else begin
              why_q   <= CmpPadExtra;
              state_q <= StRounds;
            end
          end
        end
        StRounds: begin
          if (stat_i.round_last) state_q <= StFinish;
        end
        StFinish: begin
          if (why_q == CmpPadExtra) begin
            state_q <= StClearBlk;
          end else if (last_q) begin
            state_q <= StPadFirst;
          end else begin
            state_q <= StIdle;
          end
        end
        StClearBlk: begin
          if (stat_i.pad_done) state_q <= StLenWrite;
        end
        StLenWrite: state_q <= StFinal;
        StFinal: begin
          if (stat_i.round_last) state_q <= StFinalDone;
        end
        StFinalDone: begin
          idx_q   <= '0;
          state_q <= StOut;
        end
        StOut: begin
          if (out_acc) begin
            idx_q <= idx_q + 1'b1;
            if (last_word_o) state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  a_out_only_in_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("output while accepting");
  a_idx_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && !last_word_o) |=> (idx_q == $past(idx_q) + 3'd1))
    else $error("word index skipped");
  a_out_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_word_o) |=> (state_q == StIdle)) else $error("no return to idle");

endmodule
`default_nettype wire

// File: sv/sha256_stream_hash.sv
// A byte that fills no block and ends no message leaves the input ready; one that
//   fills a block holds the input off while the 64-round compression runs.
// A last item is followed by padding, rounds and length handling; then eight
//   digest words follow, one per cycle under ready.
// The compression unit does a single round at a time and holds off the input.
// Reset (rst_ni low, asynchronous) loads the initial hash and clears the length.
`default_nettype none
module sha256_stream_hash
  import sha_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        byte_valid_i,
  input  wire logic        is_last_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);

  // The controller sequences byte loads, padding and rounds; the datapath
  // holds the block, schedule, working variables, hash and length counter.
  sha_cmd_t  cmd;
  sha_stat_t stat;

  sha_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .byte_valid_i, .is_last_i,
    .out_valid_o, .out_ready_i, .word_index_o, .last_word_o,
    .stat_i(stat), .cmd_o(cmd)
  );

  sha_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .data_byte_i, .stat_o(stat), .digest_word_o
  );

endmodule
`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import sha_pkg::*;

  // Clock, reset and the ports of the hasher.
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = '0;
  logic        byte_valid_i = 1'b0;
  logic        is_last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  localparam int unsigned CycleLimit = 1500000;
  localparam int unsigned DrainCycles = 300;

  // One expected digest word, field by field.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  always #5 clk_i = ~clk_i;

  sha256_stream_hash uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .data_byte_i, .byte_valid_i,
    .is_last_i, .out_valid_o, .out_ready_i, .digest_word_o, .word_index_o,
    .last_word_o
  );

  // The predictor keeps its own copy of the hash state.
  logic [31:0]       chain_h[8];
  logic [31:0]       msg_block[16];
  logic [CountW-1:0] byte_total;
  digest_word_t      pending_digest[$];
  int unsigned       error_count = 0;
  int unsigned       cycle_count = 0;
  int unsigned       out_wait = 0;

  localparam logic [31:0] RoundConst[64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  localparam logic [31:0] StartHash[8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // One full compression of msg_block into chain_h.
  task automatic compress_block();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++) w[i] = msg_block[i];
    for (int i = 16; i < 64; i++) begin
      w[i] = w[i-16] + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
           + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
    end
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundConst[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] += v[i];
  endtask

  // Bytes are packed big-endian into the block words.
  task automatic place_byte(input int pos, input logic [7:0] b);
    msg_block[pos / 4][(3 - pos % 4) * 8 +: 8] = b;
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) chain_h[i] = StartHash[i];
    byte_total = '0;
  endtask

  // Advances the predicted hash by one accepted item and queues the eight
  // digest words when the item ends a message.
  task automatic predict_digest(input logic [7:0] b, input logic has_byte,
                                input logic ends_msg);
    int pos;
    logic [63:0] bit_len;
    digest_word_t exp_entry;
    if (has_byte) begin
      pos = int'(byte_total[5:0]);
      place_byte(pos, b);
      byte_total = byte_total + 1'b1;
      if (pos == 63) compress_block();
    end
    if (ends_msg) begin
      pos = int'(byte_total[5:0]);
      place_byte(pos, 8'h80);
      for (int i = pos + 1; i < 64; i++) place_byte(i, 8'h00);
      // No room left for the length: close this block and pad a fresh one.
      if (pos >= 56) begin
        compress_block();
        for (int i = 0; i < 16; i++) msg_block[i] = '0;
      end
      bit_len = {byte_total, 3'b000};
      msg_block[14] = bit_len[63:32];
      msg_block[15] = bit_len[31:0];
      compress_block();
      for (int i = 0; i < 8; i++) begin
        exp_entry.word  = chain_h[i];
        exp_entry.index = 3'(i);
        exp_entry.last  = (i == 7);
        pending_digest.insert(pending_digest.size(), exp_entry);
      end
      restart_hash();
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    error_count++;
  endtask

  // Sends one item: a random gap with valid low, then valid held until it
  // is taken. Valid stays high after the handshake so that a next item with
  // no gap follows directly.
  task automatic send_item(input logic [7:0] b, input logic has_byte,
                           input logic ends_msg);
    int gap;
    gap = $urandom_range(0, 10) * int'($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    data_byte_i  <= b;
    byte_valid_i <= has_byte;
    is_last_i    <= ends_msg;
    do @(posedge clk_i); while (!in_ready_o);
    predict_digest(b, has_byte, ends_msg);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len - 1; i++) send_item(8'($urandom), 1'b1, 1'b0);
    if (len == 0) send_item(8'($urandom), 1'b0, 1'b1);
    else send_item(8'($urandom), 1'b1, 1'b1);
  endtask

  task automatic wait_for_digests();
    in_valid_i <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk_i);
  endtask

  // Directed: the empty message, a byte with the end, bytes at the field
  // extremes, an idle item in the middle, and an end-only item after bytes.
  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'ha5, 1'b0, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // The sender holds off here until every digest word has come back.
    wait_for_digests();
  endtask

  // Lengths near the padding boundaries: 55/56 decide whether the length
  // fits, 63/64 whether a block fills on the last byte.
  task automatic test_pad_boundaries();
    int lens[6] = '{55, 56, 57, 63, 64, 65};
    foreach (lens[i]) send_message(lens[i]);
  endtask

  // Random messages of mostly short lengths, with idle items sprinkled in.
  task automatic test_random_messages();
    int sent = 0;
    int len;
    while (sent < 130) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 130) : $urandom_range(0, 12);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 15) == 0) send_item(8'($urandom), 1'b0, 1'b0);
        send_item(8'($urandom), 1'b1, 1'b0);
      end
      if ($urandom_range(0, 1) == 0) send_item(8'($urandom), 1'b0, 1'b1);
      else send_item(8'($urandom), 1'b1, 1'b1);
      sent += len + 1;
    end
  endtask

  // Output side: a random wait before each word, then each accepted word is
  // checked against the oldest expected one.
  always @(posedge clk_i) begin
    digest_word_t exp_word;
    cycle_count++;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_digest.size() == 0) begin
        report_mismatch("digest word with none expected");
      end else begin
        exp_word = pending_digest.pop_front();
        if (digest_word_o !== exp_word.word)
          report_mismatch($sformatf("word %0d: got %h want %h", exp_word.index,
                                    digest_word_o, exp_word.word));
        if (word_index_o !== exp_word.index)
          report_mismatch($sformatf("index: got %0d want %0d", word_index_o,
                                    exp_word.index));
        if (last_word_o !== exp_word.last)
          report_mismatch($sformatf("last flag: got %b want %b", last_word_o,
                                    exp_word.last));
      end
    end
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) out_wait = $urandom_range(0, 10);
      else if (out_wait != 0) out_wait--;
      out_ready_i <= (out_wait == 0);
    end
  end

  always @(posedge clk_i) begin
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    restart_hash();
    for (int i = 0; i < 16; i++) msg_block[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_pad_boundaries();
    test_random_messages();
    wait_for_digests();
    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0 && pending_digest.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
sv/sha_pkg.sv
sv/sha_datapath.sv
sv/sha_ctrl.sv
sv/sha256_stream_hash.sv
bench/tb.sv
